>>> sv/ppd_pkg.sv
// ppd_pkg: widths, register indexes and stream layout for periodic_pair_distance
// no dependencies; imported by the top level
package ppd_pkg;

  localparam int COORD_W    = 32;   // signed q16.16 coordinate
  localparam int LEN_W      = 31;   // unsigned q15.16 domain length
  localparam int DIST_W     = 33;   // unsigned q17.16 distance
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SHIFT_W    = COORD_W + 2;
  localparam int MAG_W      = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int MAX_DIMS   = 3;

  localparam int IN_DATA_W  = 2 * MAX_DIMS * COORD_W;
  localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = LEN_W;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PERIODIC_MODE = 3'd0;
  localparam cfg_index_t REG_DIMS_IN_USE   = 3'd1;
  localparam cfg_index_t REG_LENGTH_X      = 3'd2;
  localparam cfg_index_t REG_LENGTH_Y      = 3'd3;
  localparam cfg_index_t REG_LENGTH_Z      = 3'd4;

  localparam logic [1:0]       DIMS_RESET   = 2'd3;
  localparam logic [LEN_W-1:0] LENGTH_RESET = 31'd65536;

endpackage

>>> sv/periodic_pair_distance.sv
// periodic_pair_distance: pipelined euclidean / minimum-image pair distance
// depends on ppd_pkg (widths, register indexes)
//
// Takes one pair of points per beat (three signed q16.16 coordinates each) and
// returns their distance in unsigned q17.16, rounded down. With periodic_mode
// set, every axis keeps the smallest of |d|, |d+L| and |d-L|, which is the
// minimum image when |d| < L. Axes at or above dims_in_use count as zero.
// The datapath is a fully pipelined chain: difference, shift by the domain
// length, magnitude, per-axis minimum, 32x32 square, three-way sum, then one
// register stage per result bit of a digit-by-digit square root. A new pair
// is taken every cycle while the output is not stalled; a stalled output
// backs the pipeline up to the input once every stage holds a beat.
// Every stage carries a valid bit and advances when it is empty or the stage
// after it advances, so bubbles are squeezed out and a stalled output keeps
// its beat while earlier stages still fill. Configuration registers are
// written through the cfg channel (always ready) and must only change while
// no pair is in flight.
module periodic_pair_distance #(
  parameter int DIMENSIONS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  // input pairs; tdata from bit 0 up: first_x, first_y, first_z,
  // second_x, second_y, second_z (32 bits each, signed)
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ppd_pkg::IN_DATA_W-1:0]     s_tdata,
  // results; tdata from bit 0 up: distance (33 bits), zero padding
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ppd_pkg::OUT_DATA_W-1:0]    m_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ppd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ppd_pkg::*;

  // sum of DIMENSIONS squares needs a few guard bits above the 64-bit square
  localparam int SUM_W  = SQ_W + $clog2(DIMENSIONS + 1);
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic             periodic_mode;
  logic [1:0]       dims_in_use;
  logic [LEN_W-1:0] length_x;
  logic [LEN_W-1:0] length_y;
  logic [LEN_W-1:0] length_z;
  logic [LEN_W-1:0] len_cfg [MAX_DIMS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_mode <= 1'b0;
      dims_in_use   <= DIMS_RESET;
      length_x      <= LENGTH_RESET;
      length_y      <= LENGTH_RESET;
      length_z      <= LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PERIODIC_MODE: periodic_mode <= cfg_data[0];
        REG_DIMS_IN_USE:   dims_in_use   <= cfg_data[1:0];
        REG_LENGTH_X:      length_x      <= cfg_data;
        REG_LENGTH_Y:      length_y      <= cfg_data;
        REG_LENGTH_Z:      length_z      <= cfg_data;
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  assign len_cfg[0] = length_x;
  assign len_cfg[1] = length_y;
  assign len_cfg[2] = length_z;

  // ---------------------------------------------------------------------
  // stage valids and advance chain
  // a stage advances when it is empty or its successor advances
  // ---------------------------------------------------------------------
  logic              v_a, v_b, v_c, v_d, v_e, v_f;
  logic              adv_a, adv_b, adv_c, adv_d, adv_e, adv_f;
  logic [ROOT_W-1:0] rt_v;
  logic [ROOT_W-1:0] rt_adv;

  genvar k;
  generate
    for (k = 0; k < ROOT_W; k++) begin : g_adv
      if (k == ROOT_W - 1) begin : g_last
        assign rt_adv[k] = !rt_v[k] || m_tready;
      end else begin : g_mid
        assign rt_adv[k] = !rt_v[k] || rt_adv[k+1];
      end
    end
  endgenerate

  assign adv_f = !v_f || rt_adv[0];
  assign adv_e = !v_e || adv_f;
  assign adv_d = !v_d || adv_e;
  assign adv_c = !v_c || adv_d;
  assign adv_b = !v_b || adv_c;
  assign adv_a = !v_a || adv_b;

  assign s_tready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
    end else begin
      if (adv_a) v_a <= s_tvalid;
      if (adv_b) v_b <= v_a;
      if (adv_c) v_c <= v_b;
      if (adv_d) v_d <= v_c;
      if (adv_e) v_e <= v_d;
      if (adv_f) v_f <= v_e;
    end
  end

  // ---------------------------------------------------------------------
  // per-axis lanes: difference, shifted copies, magnitudes, minimum, square
  // ---------------------------------------------------------------------
  logic signed [DIFF_W-1:0]  diff    [DIMENSIONS];
  logic signed [SHIFT_W-1:0] sh_zero [DIMENSIONS];
  logic signed [SHIFT_W-1:0] sh_up   [DIMENSIONS];
  logic signed [SHIFT_W-1:0] sh_dn   [DIMENSIONS];
  logic [MAG_W-1:0]          mag_z   [DIMENSIONS];
  logic [MAG_W-1:0]          mag_u   [DIMENSIONS];
  logic [MAG_W-1:0]          mag_d   [DIMENSIONS];
  logic [COORD_W-1:0]        term    [DIMENSIONS];
  logic [SQ_W-1:0]           square  [DIMENSIONS];

  genvar i;
  generate
    for (i = 0; i < DIMENSIONS; i++) begin : g_lane
      logic signed [COORD_W-1:0] c_first, c_second;
      logic signed [DIFF_W-1:0]  diff_next;
      logic signed [SHIFT_W-1:0] len_s;
      logic [MAG_W-1:0]          best_next;

      assign c_first  = s_tdata[i*COORD_W +: COORD_W];
      assign c_second = s_tdata[(i+MAX_DIMS)*COORD_W +: COORD_W];

      // an axis that does not take part enters as zero difference,
      // which also gives zero after the periodic minimum
      always_comb begin
        if (dims_in_use > 2'(i)) begin
          diff_next = DIFF_W'(c_first) - DIFF_W'(c_second);
        end else begin
          diff_next = '0;
        end
      end

      assign len_s = SHIFT_W'($signed({1'b0, len_cfg[i]}));

      // smallest magnitude; never above |d|, so it fits in 32 bits
      always_comb begin
        best_next = mag_z[i];
        if (periodic_mode) begin
          if (mag_u[i] < best_next) best_next = mag_u[i];
          if (mag_d[i] < best_next) best_next = mag_d[i];
        end
      end

      always_ff @(posedge clk) begin
        if (adv_a) diff[i] <= diff_next;
        if (adv_b) begin
          sh_zero[i] <= SHIFT_W'(diff[i]);
          sh_up[i]   <= SHIFT_W'(diff[i]) + len_s;
          sh_dn[i]   <= SHIFT_W'(diff[i]) - len_s;
        end
        if (adv_c) begin
          mag_z[i] <= MAG_W'(sh_zero[i][SHIFT_W-1] ? -sh_zero[i] : sh_zero[i]);
          mag_u[i] <= MAG_W'(sh_up[i][SHIFT_W-1]   ? -sh_up[i]   : sh_up[i]);
          mag_d[i] <= MAG_W'(sh_dn[i][SHIFT_W-1]   ? -sh_dn[i]   : sh_dn[i]);
        end
        if (adv_d) term[i]   <= best_next[COORD_W-1:0];
        if (adv_e) square[i] <= SQ_W'(term[i]) * SQ_W'(term[i]);
      end
    end
  endgenerate

  // ---------------------------------------------------------------------
  // sum of squares, exact
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] sum_sq;

  always_comb begin
    sum_next = '0;
    for (int n = 0; n < DIMENSIONS; n++) begin
      sum_next = sum_next + SUM_W'(square[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_f) sum_sq <= sum_next;
  end

  // ---------------------------------------------------------------------
  // square root, one result bit per stage (restoring, non-multiplying)
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0] rt_root [ROOT_W];
  logic [REM_W-1:0]  rt_rem  [ROOT_W];
  logic [PAD_W-1:0]  rt_x    [ROOT_W];

  generate
    for (k = 0; k < ROOT_W; k++) begin : g_root
      logic [ROOT_W-1:0] root_in;
      logic [REM_W-1:0]  rem_in;
      logic [PAD_W-1:0]  x_in;
      logic              v_in;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              take;

      if (k == 0) begin : g_first
        assign root_in = '0;
        assign rem_in  = '0;
        assign x_in    = PAD_W'(sum_sq);
        assign v_in    = v_f;
      end else begin : g_next
        assign root_in = rt_root[k-1];
        assign rem_in  = rt_rem[k-1];
        assign x_in    = rt_x[k-1];
        assign v_in    = rt_v[k-1];
      end

      assign rem_sh = {rem_in[REM_W-3:0], x_in[PAD_W-1 -: 2]};
      assign trial  = {root_in, 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (rst) begin
          rt_v[k] <= 1'b0;
        end else if (rt_adv[k]) begin
          rt_v[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (rt_adv[k]) begin
          rt_root[k] <= {root_in[ROOT_W-2:0], take};
          rt_rem[k]  <= take ? rem_sh - trial : rem_sh;
          rt_x[k]    <= x_in << 2;
        end
      end
    end
  endgenerate

  // last root stage doubles as the output register
  assign m_tvalid = rt_v[ROOT_W-1];
  assign m_tdata  = OUT_DATA_W'(DIST_W'(rt_root[ROOT_W-1]));

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // a ready sink never backs the pipeline up to the input
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output was ready");

  // an accepted beat lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v_a)
    else $error("accepted beat missing from first stage");

  // root remainder stays within 2*root, otherwise a bit decision was wrong
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    rt_v[ROOT_W-1] |-> (rt_rem[ROOT_W-1] <= REM_W'({rt_root[ROOT_W-1], 1'b0})))
    else $error("square root remainder out of range");

  // an output beat held by the sink keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule
